@@ design/assert_macros.svh @@
// Assertion macros used by the encryption core RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define ASSERT_IMPL(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication checked outside reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ design/aes_pkg.sv @@
// AES-128 package: S-box table, GF(2^8) helpers and round constants.
package aes_pkg;

   typedef logic [7:0] byte_type;
   typedef logic [127:0] block_type;

   localparam int unsigned NumRounds = 10;

   localparam byte_type AffineConst = 8'h63;
   localparam byte_type PolyLow = 8'h1b;

   // Forward S-box table.
   localparam logic [0:255][7:0] SBOX = {
      8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
      8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
      8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
      8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
      8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
      8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
      8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
      8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
      8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
      8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
      8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
      8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
      8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
      8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
      8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
      8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
   };

   // Round constants for rounds 1..10 (index 0 unused).
   localparam logic [0:10][7:0] RCON = {
      8'h00,8'h01,8'h02,8'h04,8'h08,8'h10,8'h20,8'h40,8'h80,8'h1b,8'h36
   };

   function automatic byte_type xtime(input byte_type a);
      xtime = {a[6:0], 1'b0} ^ (a[7] ? PolyLow : 8'h00);
   endfunction

   // Byte i sits at bits [127-8i -: 8].
   function automatic byte_type get_byte(input block_type b, input int unsigned i);
      get_byte = b[127 - 8*i -: 8];
   endfunction

   // SubBytes and ShiftRows together.
   function automatic block_type sub_shift(input block_type s);
      block_type t;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         for (int r = 0; r < 4; r++) begin
            t[127 - 8*(r + 4*c) -: 8] = SBOX[get_byte(s, r + 4*((c + r) % 4))];
         end
      end
      sub_shift = t;
   endfunction

   function automatic block_type mix_columns(input block_type s);
      block_type t;
      byte_type a0, a1, a2, a3;
      t = '0;
      for (int c = 0; c < 4; c++) begin
         a0 = get_byte(s, 4*c);
         a1 = get_byte(s, 4*c + 1);
         a2 = get_byte(s, 4*c + 2);
         a3 = get_byte(s, 4*c + 3);
         t[127 - 32*c -: 8] = xtime(a0) ^ xtime(a1) ^ a1 ^ a2 ^ a3;
         t[119 - 32*c -: 8] = a0 ^ xtime(a1) ^ xtime(a2) ^ a2 ^ a3;
         t[111 - 32*c -: 8] = a0 ^ a1 ^ xtime(a2) ^ xtime(a3) ^ a3;
         t[103 - 32*c -: 8] = xtime(a0) ^ a0 ^ a1 ^ a2 ^ xtime(a3);
      end
      mix_columns = t;
   endfunction

   // Next round key from the current one.
   function automatic block_type next_key(input block_type k, input byte_type rc);
      logic [31:0] w0, w1, w2, w3, t;
      w0 = k[127:96];
      w1 = k[95:64];
      w2 = k[63:32];
      w3 = k[31:0];
      t = {SBOX[w3[23:16]] ^ rc, SBOX[w3[15:8]], SBOX[w3[7:0]], SBOX[w3[31:24]]};
      w0 = w0 ^ t;
      w1 = w1 ^ w0;
      w2 = w2 ^ w1;
      w3 = w3 ^ w2;
      next_key = {w0, w1, w2, w3};
   endfunction

endpackage

@@ design/aes128_block_encrypt.sv @@
// AES-128 encryption core: eleven-stage round pipeline with on-the-fly key schedule.
//
//  channel | ports                          | direction
//  req     | req_valid/ready, key, plain    | in
//  rsp     | rsp_valid/ready, cipher        | out
//
// One block enters per cycle while rsp is not stalled; there is one stage per
// round plus the initial key add, each stage registering state and key.
// Synchronous active-high reset clears only the stage valid bits.
// A stage advances when it is empty or the stage after it moves; a stall at
// rsp backs up through all stages without dropping or repeating a word.
module aes128_block_encrypt (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [63:0] req_key_hi,
   input  logic [63:0] req_key_lo,
   input  logic [63:0] req_plain_hi,
   input  logic [63:0] req_plain_lo,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [63:0] rsp_cipher_hi,
   output logic [63:0] rsp_cipher_lo
);
   import aes_pkg::*;
`include "assert_macros.svh"

   localparam int unsigned NumStages = NumRounds + 1;

   logic      [NumStages-1:0] valid_ff;
   block_type                 state_ff [NumStages];
   block_type                 key_ff   [NumStages];
   logic      [NumStages-1:0] adv;

   // Per-stage advance: empty slot or downstream moving.
   always_comb begin
      adv[NumStages-1] = !valid_ff[NumStages-1] || rsp_ready;
      for (int i = NumStages - 2; i >= 0; i--) begin
         adv[i] = !valid_ff[i] || adv[i+1];
      end
   end

   assign req_ready = adv[0];

   // Valid bits.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         if (adv[0]) valid_ff[0] <= req_valid;
         for (int i = 1; i < NumStages; i++) begin
            if (adv[i]) valid_ff[i] <= valid_ff[i-1];
         end
      end
   end

   // Stage 0: initial key add.
   always_ff @(posedge clock) begin
      if (adv[0]) begin
         key_ff[0]   <= {req_key_hi, req_key_lo};
         state_ff[0] <= {req_plain_hi, req_plain_lo} ^ {req_key_hi, req_key_lo};
      end
   end

   // Stages 1..10: one round each.
   for (genvar g = 1; g < NumStages; g++) begin : g_round
      block_type key_in, state_in, ss;
      always_comb begin
         key_in = next_key(key_ff[g-1], RCON[g]);
         ss     = sub_shift(state_ff[g-1]);
         if (g < NumRounds) state_in = mix_columns(ss) ^ key_in;
         else               state_in = ss ^ key_in;
      end
      always_ff @(posedge clock) begin
         if (adv[g]) begin
            key_ff[g]   <= key_in;
            state_ff[g] <= state_in;
         end
      end
   end

   assign rsp_valid     = valid_ff[NumStages-1];
   assign rsp_cipher_hi = state_ff[NumStages-1][127:64];
   assign rsp_cipher_lo = state_ff[NumStages-1][63:0];

   `ASSERT_NEXT(a_hold_out, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "output word lost under stall")
   `ASSERT_IMPL(a_ready_full, clock, reset, !req_ready, &valid_ff, "ready low with a free stage")
   `ASSERT_NEXT(a_enter, clock, reset, req_valid && req_ready, valid_ff[0], "accepted word not captured")

endmodule

@@ tb/sv/aes128_block_encrypt_checker.sv @@
// Checker for the AES-128 encryption core: predicts ciphertext and compares each word.
`timescale 1ns / 1ps

module aes128_block_encrypt_checker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [63:0] req_key_hi,
   input  logic [63:0] req_key_lo,
   input  logic [63:0] req_plain_hi,
   input  logic [63:0] req_plain_lo,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic [63:0] rsp_cipher_hi,
   input  logic [63:0] rsp_cipher_lo,
   output int          error_count,
   output int          pending_count,
   output int          cipher_count
);

   typedef logic [7:0] octet_t;
   typedef octet_t blk_t [16];

   logic [127:0] cipher_queue [$];

   // GF(2^8) multiply, modulus x^8+x^4+x^3+x+1
   function automatic octet_t gmul(input octet_t x, input octet_t y);
      octet_t a, b, p;
      a = x;
      b = y;
      p = 8'h00;
      for (int i = 0; i < 8; i++) begin
         if (b[0]) p ^= a;
         a = a[7] ? ({a[6:0], 1'b0} ^ 8'h1b) : {a[6:0], 1'b0};
         b = b >> 1;
      end
      return p;
   endfunction

   // S-box computed from the field inverse and the affine map
   function automatic octet_t sbox_calc(input octet_t x);
      octet_t sq, inv, r;
      sq = x;
      inv = 8'h01;
      for (int i = 0; i < 7; i++) begin
         sq = gmul(sq, sq);
         inv = gmul(inv, sq);
      end
      if (x == 8'h00) inv = 8'h00;
      r = inv ^ {inv[6:0], inv[7]} ^ {inv[5:0], inv[7:6]} ^ {inv[4:0], inv[7:5]}
          ^ {inv[3:0], inv[7:4]} ^ 8'h63;
      return r;
   endfunction

   function automatic logic [127:0] encrypt_block(input logic [127:0] key,
                                                  input logic [127:0] plain);
      blk_t k, s, t;
      octet_t rc, a0, a1, a2, a3;
      octet_t w [4];
      logic [127:0] res;
      for (int i = 0; i < 16; i++) begin
         k[i] = key[127 - 8*i -: 8];
         s[i] = plain[127 - 8*i -: 8] ^ k[i];
      end
      rc = 8'h01;
      for (int rnd = 1; rnd <= 10; rnd++) begin
         // key schedule step
         w[0] = sbox_calc(k[13]) ^ rc;
         w[1] = sbox_calc(k[14]);
         w[2] = sbox_calc(k[15]);
         w[3] = sbox_calc(k[12]);
         for (int i = 0; i < 4; i++) k[i] ^= w[i];
         for (int i = 4; i < 16; i++) k[i] ^= k[i-4];
         rc = gmul(rc, 8'h02);
         // SubBytes + ShiftRows
         for (int c = 0; c < 4; c++)
            for (int r = 0; r < 4; r++)
               t[r + 4*c] = sbox_calc(s[r + 4*((c + r) % 4)]);
         s = t;
         if (rnd < 10) begin
            for (int c = 0; c < 4; c++) begin
               a0 = s[4*c]; a1 = s[4*c+1]; a2 = s[4*c+2]; a3 = s[4*c+3];
               s[4*c]   = gmul(a0, 8'h02) ^ gmul(a1, 8'h03) ^ a2 ^ a3;
               s[4*c+1] = a0 ^ gmul(a1, 8'h02) ^ gmul(a2, 8'h03) ^ a3;
               s[4*c+2] = a0 ^ a1 ^ gmul(a2, 8'h02) ^ gmul(a3, 8'h03);
               s[4*c+3] = gmul(a0, 8'h03) ^ a1 ^ a2 ^ gmul(a3, 8'h02);
            end
         end
         for (int i = 0; i < 16; i++) s[i] ^= k[i];
      end
      for (int i = 0; i < 16; i++) res[127 - 8*i -: 8] = s[i];
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [63:0] got,
                                  input logic [63:0] want);
      $display("MISMATCH %s: got %h expected %h at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   assign pending_count = cipher_queue.size();

   initial begin
      error_count = 0;
      cipher_count = 0;
   end

   // watch both channels at each edge
   always @(posedge clock) begin
      logic [127:0] want;
      if (!reset) begin
         if (req_valid && req_ready)
            cipher_queue.push_back(encrypt_block({req_key_hi, req_key_lo},
                                                 {req_plain_hi, req_plain_lo}));
         if (rsp_valid && rsp_ready) begin
            cipher_count++;
            if (cipher_queue.size() == 0) begin
               $display("UNEXPECTED word %h_%h at %0t", rsp_cipher_hi, rsp_cipher_lo,
                        $realtime);
               error_count++;
            end else begin
               want = cipher_queue.pop_front();
               if (rsp_cipher_hi !== want[127:64])
                  report_mismatch("cipher_hi", rsp_cipher_hi, want[127:64]);
               if (rsp_cipher_lo !== want[63:0])
                  report_mismatch("cipher_lo", rsp_cipher_lo, want[63:0]);
            end
         end
      end
   end

endmodule

@@ tb/sv/tb_aes128_block_encrypt.sv @@
// Top of the AES-128 encryption testbench: stimulus, stall patterns and verdict.
`timescale 1ns / 1ps

module tb_aes128_block_encrypt;

   localparam int CycleLimit = 400000;
   localparam int DrainCycles = 30;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [63:0] req_key_hi = '0;
   logic [63:0] req_key_lo = '0;
   logic [63:0] req_plain_hi = '0;
   logic [63:0] req_plain_lo = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [63:0] rsp_cipher_hi;
   logic [63:0] rsp_cipher_lo;

   int error_count, pending_count, cipher_count;
   int send_idle_pct = 0;
   int stall_pct = 0;
   int cycle_count = 0;
   int sent_count = 0;

   always #4 clock = ~clock;

   aes128_block_encrypt dut (.*);

   aes128_block_encrypt_checker checker_i (.*);

   // receiver backpressure
   always @(posedge clock)
      rsp_ready <= ($urandom_range(99) >= stall_pct);

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CycleLimit) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   // hold one word until accepted; random idle cycles ahead of it
   task automatic send_word(input logic [63:0] kh, input logic [63:0] kl,
                            input logic [63:0] ph, input logic [63:0] pl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_key_hi <= kh;
      req_key_lo <= kl;
      req_plain_hi <= ph;
      req_plain_lo <= pl;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      sent_count++;
   endtask

   task automatic drop_valid();
      req_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_random(input int n);
      logic [63:0] kh, kl;
      for (int i = 0; i < n; i++) begin
         // some fixed key halves, some sparse/dense patterns
         kh = rand64();
         kl = rand64();
         case ($urandom_range(5))
            0: send_word(kh, kl, '0, '0);
            1: send_word('1, kl, rand64(), '1);
            2: send_word(kh, kl, rand64() & rand64(), rand64() | rand64());
            default: send_word(kh, kl, rand64(), rand64());
         endcase
      end
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: FIPS-197 vectors, all-zero and all-one fields, alternating bits, single set bits
      send_word(64'h2b7e151628aed2a6, 64'habf7158809cf4f3c,
                64'h3243f6a8885a308d, 64'h313198a2e0370734);
      send_word(64'h0001020304050607, 64'h08090a0b0c0d0e0f,
                64'h0011223344556677, 64'h8899aabbccddeeff);
      send_word('0, '0, '0, '0);
      send_word('1, '1, '1, '1);
      send_word('0, '0, '1, '1);
      send_word('1, '1, '0, '0);
      send_word(64'h5555555555555555, 64'haaaaaaaaaaaaaaaa,
                64'haaaaaaaaaaaaaaaa, 64'h5555555555555555);
      for (int b = 0; b < 8; b++)
         send_word(64'h1 << (8*b+7), 64'h1 << (8*b), 64'h1 << (8*b+3),
                   64'h1 << (8*b+5));
      drop_valid();

      // hold off until the pipeline is empty
      while (pending_count != 0) @(posedge clock);

      send_idle_pct = 0;  stall_pct = 0;  send_random(200);
      send_idle_pct = 84; stall_pct = 0;  send_random(200);
      send_idle_pct = 0;  stall_pct = 84; send_random(200);
      send_idle_pct = 35; stall_pct = 35; send_random(200);
      drop_valid();
      stall_pct = 0;

      while (pending_count != 0) @(posedge clock);
      repeat (DrainCycles) @(posedge clock);

      $display("Sent %0d blocks, checked %0d ciphertext words across four stall mixes.",
               sent_count, cipher_count);
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
